// ===== design/lfr_pkg.sv =====
package lfr_pkg;

  // Table geometry defaults
  localparam int NUM_PAGES_DEF  = 32;
  localparam int STAMP_BITS_DEF = 16;

  // Fixed field widths
  localparam int ADDR_W     = 15;
  localparam int PAGE_W     = 5;
  localparam int FAULT_W    = 16;
  localparam int LIMIT_W    = 6;
  localparam int PSIZE_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Smallest page is 1 KiB
  localparam logic [PSIZE_W-1:0] MIN_PAGE_SHIFT = 4'd10;
  localparam logic [FAULT_W-1:0] FAULT_TOP      = {FAULT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE    = 2'd2;

  // Configuration reset values
  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = 6'd4;
  localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST   = 4'd10;
  localparam logic               POLICY_RST      = 1'b0;

  // Replacement policy codes
  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_EVICT
  } lfr_state_t;

  // Wavefront control that travels down the cell row
  typedef struct packed {
    logic vld;
    logic found;
  } scan_ctl_t;

  // Broadcast update command to all cells
  typedef struct packed {
    logic wr_en;
    logic clr_en;
  } cell_cmd_t;

endpackage

// ===== design/lfr_cell.sv =====
module lfr_cell #(
  parameter int IDX_W      = 5,
  parameter int STAMP_BITS = 16,
  parameter int CELL_IDX   = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lfr_pkg::cell_cmd_t     cmd,
  input  logic [IDX_W-1:0]       wr_idx,
  input  logic [IDX_W-1:0]       clr_idx,
  input  logic [STAMP_BITS-1:0]  wr_stamp,
  input  lfr_pkg::scan_ctl_t     ctl_in,
  input  logic [STAMP_BITS-1:0]  best_in,
  input  logic [IDX_W-1:0]       idx_in,
  output lfr_pkg::scan_ctl_t     ctl_out,
  output logic [STAMP_BITS-1:0]  best_out,
  output logic [IDX_W-1:0]       idx_out,
  output logic                   resident
);
  import lfr_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                  resident_r, resident_nxt;
  logic [STAMP_BITS-1:0] stamp_r, stamp_nxt;
  scan_ctl_t             ctl_r, ctl_nxt;
  logic [STAMP_BITS-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  take;

  // Apply broadcast load and evict commands
  always_comb begin
    resident_nxt = resident_r;
    stamp_nxt    = stamp_r;
    if (cmd.wr_en && (wr_idx == MY_IDX)) begin
      resident_nxt = 1'b1;
      stamp_nxt    = wr_stamp;
    end
    if (cmd.clr_en && (clr_idx == MY_IDX)) begin
      resident_nxt = 1'b0;
    end
  end

  // Compare own stamp against the running oldest; strict less keeps lowest index
  always_comb begin
    take             = resident_r && (!ctl_in.found || (stamp_r < best_in));
    ctl_nxt.vld      = ctl_in.vld;
    ctl_nxt.found    = ctl_in.found || resident_r;
    best_nxt         = take ? stamp_r : best_in;
    idx_nxt          = take ? MY_IDX : idx_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resident_r <= 1'b0;
      ctl_r      <= '0;
    end else begin
      resident_r <= resident_nxt;
      ctl_r      <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r <= stamp_nxt;
    best_r  <= best_nxt;
    idx_r   <= idx_nxt;
  end

  assign ctl_out  = ctl_r;
  assign best_out = best_r;
  assign idx_out  = idx_r;
  assign resident = resident_r;

endmodule

// ===== design/lfr_chain.sv =====
module lfr_chain #(
  parameter int NUM_PAGES  = 32,
  parameter int STAMP_BITS = 16,
  parameter int IDX_W      = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lfr_pkg::cell_cmd_t    cmd,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [IDX_W-1:0]      clr_idx,
  input  logic [STAMP_BITS-1:0] wr_stamp,
  input  logic                  scan_start,
  input  logic [IDX_W-1:0]      look_idx,
  output logic                  look_hit,
  output lfr_pkg::scan_ctl_t    scan_end,
  output logic [IDX_W-1:0]      victim_idx
);
  import lfr_pkg::*;

  scan_ctl_t             ctl_w  [NUM_PAGES+1];
  logic [STAMP_BITS-1:0] best_w [NUM_PAGES+1];
  logic [IDX_W-1:0]      idx_w  [NUM_PAGES+1];
  logic [NUM_PAGES-1:0]  res_vec;

  // Inject a fresh wavefront at the head of the row
  assign ctl_w[0].vld   = scan_start;
  assign ctl_w[0].found = 1'b0;
  assign best_w[0]      = '0;
  assign idx_w[0]       = '0;

  for (genvar k = 0; k < NUM_PAGES; k++) begin : g_cell
    lfr_cell #(
      .IDX_W      (IDX_W),
      .STAMP_BITS (STAMP_BITS),
      .CELL_IDX   (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .wr_idx   (wr_idx),
      .clr_idx  (clr_idx),
      .wr_stamp (wr_stamp),
      .ctl_in   (ctl_w[k]),
      .best_in  (best_w[k]),
      .idx_in   (idx_w[k]),
      .ctl_out  (ctl_w[k+1]),
      .best_out (best_w[k+1]),
      .idx_out  (idx_w[k+1]),
      .resident (res_vec[k])
    );
  end

  // Select the resident flag of the referenced page
  assign look_hit   = res_vec[look_idx];
  assign scan_end   = ctl_w[NUM_PAGES];
  assign victim_idx = idx_w[NUM_PAGES];

endmodule

// ===== design/lru_fifo_page_replacer.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_virtual_address
// out_     output     out_valid/out_stall out_page_number, out_hit, out_evict_valid,
//                                         out_evicted_page, out_fault_count,
//                                         out_stamp_exhausted
// cfg_     input      cfg_wr_en          cfg_index, cfg_wdata
//
// A hit, or a miss with a free frame, is accepted in ST_IDLE, then looked up and
// updated in ST_LOOK. A miss that must evict goes through ST_SCAN to ST_EVICT;
// the oldest-stamp search runs as a wavefront through the NUM_PAGES cells, one
// cell a cycle. One transaction is in flight at a time; the result register
// frees the input side while a finished result waits; a stalled output holds the
// update back. Reset is synchronous; the table comes up empty, no clearing pass.
module lru_fifo_page_replacer #(
  parameter int NUM_PAGES  = lfr_pkg::NUM_PAGES_DEF,
  parameter int STAMP_BITS = lfr_pkg::STAMP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lfr_pkg::ADDR_W-1:0]    in_virtual_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lfr_pkg::PAGE_W-1:0]    out_page_number,
  output logic                          out_hit,
  output logic                          out_evict_valid,
  output logic [lfr_pkg::PAGE_W-1:0]    out_evicted_page,
  output logic [lfr_pkg::FAULT_W-1:0]   out_fault_count,
  output logic                          out_stamp_exhausted,
  input  logic                          cfg_wr_en,
  input  logic [lfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lfr_pkg::*;

  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam int CNT_W = $clog2(NUM_PAGES + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int MOD_W = 14;
  localparam logic [MOD_W-1:0]      NP_M      = MOD_W'(NUM_PAGES);
  localparam logic [STAMP_BITS-1:0] STAMP_TOP = {STAMP_BITS{1'b1}};
  localparam logic [STAMP_BITS-1:0] STAMP_ONE = STAMP_BITS'(1);

  // Configuration
  logic [LIMIT_W-1:0] frame_limit_r;
  logic [PSIZE_W-1:0] page_size_log2_r;
  logic               policy_mode_r;

  // Control state
  lfr_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [STAMP_BITS-1:0] stamp_clk_r, stamp_clk_nxt;
  logic [FAULT_W-1:0] fault_r, fault_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Per-transaction payload
  logic [IDX_W-1:0]   page_idx_r;
  logic [PAGE_W-1:0]  page_num_r;
  logic [IDX_W-1:0]   victim_r;
  logic               found_r;
  logic [PAGE_W-1:0]  page_num_nxt;
  logic [PAGE_W-1:0]  out_page_number_r;
  logic               out_hit_r;
  logic               out_evict_valid_r;
  logic [PAGE_W-1:0]  out_evicted_page_r;
  logic [FAULT_W-1:0] out_fault_count_r;
  logic               out_stamp_exhausted_r;

  // Datapath signals
  logic               accept;
  logic               out_free;
  logic [PSIZE_W-1:0] shift;
  logic [PAGE_W-1:0]  page_raw;
  logic [MOD_W-1:0]   mod_rem;
  logic [LIMIT_W-1:0] limit;
  logic               table_full;
  logic               look_hit;
  logic               need_evict;
  logic               scan_start;
  logic               commit;
  logic               evicting;
  logic               do_stamp;
  scan_ctl_t          scan_end;
  logic [IDX_W-1:0]   victim_idx;
  cell_cmd_t          cmd;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Derive page number: shift out the page offset, wrap into the table
  always_comb begin
    shift    = (page_size_log2_r < MIN_PAGE_SHIFT) ? MIN_PAGE_SHIFT : page_size_log2_r;
    page_raw = PAGE_W'(in_virtual_address >> shift);
    mod_rem  = MOD_W'(page_raw);
    for (int j = PAGE_W - 1; j >= 0; j--) begin
      if (mod_rem >= (NP_M << j)) begin
        mod_rem = mod_rem - (NP_M << j);
      end
    end
    page_num_nxt = PAGE_W'(mod_rem);
  end

  // Occupancy check against the frame limit
  always_comb begin
    limit      = (frame_limit_r == '0) ? LIMIT_W'(1) : frame_limit_r;
    table_full = CMP_W'(count_r) >= CMP_W'(limit);
    need_evict = !look_hit && table_full;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (need_evict) state_nxt = ST_SCAN;
        else if (out_free) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_end.vld) state_nxt = ST_EVICT;
      end
      ST_EVICT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall   = 1'b1;
    scan_start = 1'b0;
    commit     = 1'b0;
    evicting   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_LOOK: begin
        scan_start = need_evict;
        commit     = !need_evict && out_free;
      end
      ST_SCAN: begin
        scan_start = 1'b0;
      end
      ST_EVICT: begin
        commit   = out_free;
        evicting = found_r;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Table update and running counters
  always_comb begin
    do_stamp      = !look_hit || (policy_mode_r == POLICY_LRU);
    cmd.wr_en     = commit && do_stamp;
    cmd.clr_en    = commit && evicting;
    stamp_clk_nxt = stamp_clk_r;
    fault_nxt     = fault_r;
    count_nxt     = count_r;
    if (commit && do_stamp && (stamp_clk_r != STAMP_TOP)) begin
      stamp_clk_nxt = stamp_clk_r + STAMP_ONE;
    end
    if (commit && !look_hit) begin
      if (fault_r != FAULT_TOP) fault_nxt = fault_r + FAULT_W'(1);
      if (!evicting) count_nxt = count_r + CNT_W'(1);
    end
    out_valid_nxt = commit || (out_valid_r && out_stall);
  end

  lfr_chain #(
    .NUM_PAGES  (NUM_PAGES),
    .STAMP_BITS (STAMP_BITS),
    .IDX_W      (IDX_W)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .wr_idx     (page_idx_r),
    .clr_idx    (victim_r),
    .wr_stamp   (stamp_clk_r),
    .scan_start (scan_start),
    .look_idx   (page_idx_r),
    .look_hit   (look_hit),
    .scan_end   (scan_end),
    .victim_idx (victim_idx)
  );

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      count_r          <= '0;
      stamp_clk_r      <= STAMP_ONE;
      fault_r          <= '0;
      out_valid_r      <= 1'b0;
      frame_limit_r    <= FRAME_LIMIT_RST;
      page_size_log2_r <= PAGE_SIZE_RST;
      policy_mode_r    <= POLICY_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      stamp_clk_r <= stamp_clk_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_FRAME_LIMIT:    frame_limit_r    <= LIMIT_W'(cfg_wdata);
          CFG_PAGE_SIZE_LOG2: page_size_log2_r <= PSIZE_W'(cfg_wdata);
          CFG_POLICY_MODE:    policy_mode_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // Capture transaction payload, search result and finished result
  always_ff @(posedge clk) begin
    if (accept) begin
      page_num_r <= page_num_nxt;
      page_idx_r <= IDX_W'(page_num_nxt);
    end
    if ((state_r == ST_SCAN) && scan_end.vld) begin
      victim_r <= victim_idx;
      found_r  <= scan_end.found;
    end
    if (commit) begin
      out_page_number_r     <= page_num_r;
      out_hit_r             <= look_hit;
      out_evict_valid_r     <= evicting;
      out_evicted_page_r    <= evicting ? PAGE_W'(victim_r) : '0;
      out_fault_count_r     <= fault_nxt;
      out_stamp_exhausted_r <= (stamp_clk_nxt == STAMP_TOP);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_page_number     = out_page_number_r;
  assign out_hit             = out_hit_r;
  assign out_evict_valid     = out_evict_valid_r;
  assign out_evicted_page    = out_evicted_page_r;
  assign out_fault_count     = out_fault_count_r;
  assign out_stamp_exhausted = out_stamp_exhausted_r;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import lfr_pkg::*;

  localparam int NUM_PAGES = NUM_PAGES_DEF;
  localparam int STAMP_W = STAMP_BITS_DEF;
  localparam logic [STAMP_W-1:0] STAMP_TOP = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int SETTLE_CYCLES = NUM_PAGES + 8;
  localparam longint CYCLE_LIMIT = 64'd300_000;
  localparam int MAX_PRINTED = 100;
  localparam int SEGMENTS_PER_PHASE = 4;
  localparam int SEGMENT_ITEMS = 54;

  typedef struct packed {
    logic [PAGE_W-1:0]  page_number;
    logic               hit;
    logic               evict_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_count;
    logic               stamp_exhausted;
  } page_result_t;

  typedef enum logic {
    ROW_ACCESS,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  wdata;
    logic [ADDR_W-1:0]      addr;
    logic                   typed;
    page_result_t           want;
  } plan_row_t;

  localparam page_result_t NO_RESULT = '0;
  localparam int NUM_ROWS = 30;

  // Directed sequence; the first rows start from the reset table and
  // carry their expected result, the rest go through the predictor
  localparam plan_row_t DIRECTED_PLAN [NUM_ROWS] = '{
    '{ROW_ACCESS, '0, '0, 15'h0000, 1'b1, '{5'd0, 1'b0, 1'b0, 5'd0, 16'd1, 1'b0}},
    '{ROW_ACCESS, '0, '0, 15'h7FFF, 1'b1, '{5'd31, 1'b0, 1'b0, 5'd0, 16'd2, 1'b0}},
    '{ROW_ACCESS, '0, '0, 15'h03FF, 1'b1, '{5'd0, 1'b1, 1'b0, 5'd0, 16'd2, 1'b0}},
    '{ROW_ACCESS, '0, '0, 15'h0400, 1'b1, '{5'd1, 1'b0, 1'b0, 5'd0, 16'd3, 1'b0}},
    '{ROW_ACCESS, '0, '0, 15'h0800, 1'b1, '{5'd2, 1'b0, 1'b0, 5'd0, 16'd4, 1'b0}},
    '{ROW_ACCESS, '0, '0, 15'h0C00, 1'b1, '{5'd3, 1'b0, 1'b1, 5'd31, 16'd5, 1'b0}},
    '{ROW_WRITE, CFG_POLICY_MODE, 6'(POLICY_FIFO), '0, 1'b0, NO_RESULT},
    '{ROW_WRITE, CFG_PAGE_SIZE_LOG2, 6'd5, '0, 1'b0, NO_RESULT},
    '{ROW_WRITE, CFG_FRAME_LIMIT, 6'd63, '0, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h7C00, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h0C00, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h1234, 1'b0, NO_RESULT},
    '{ROW_WRITE, CFG_FRAME_LIMIT, 6'd0, '0, 1'b0, NO_RESULT},
    '{ROW_WRITE, CFG_PAGE_SIZE_LOG2, 6'd12, '0, 1'b0, NO_RESULT},
    '{ROW_WRITE, CFG_UNUSED_IDX, 6'd63, '0, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h5000, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h6FFF, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h0000, 1'b0, NO_RESULT},
    '{ROW_WRITE, CFG_PAGE_SIZE_LOG2, 6'd14, '0, 1'b0, NO_RESULT},
    '{ROW_WRITE, CFG_POLICY_MODE, 6'(POLICY_LRU), '0, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h4000, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h7FFF, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h0000, 1'b0, NO_RESULT},
    '{ROW_WRITE, CFG_PAGE_SIZE_LOG2, 6'd15, '0, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h7FFF, 1'b0, NO_RESULT},
    '{ROW_WRITE, CFG_PAGE_SIZE_LOG2, 6'd13, '0, 1'b0, NO_RESULT},
    '{ROW_WRITE, CFG_FRAME_LIMIT, 6'd32, '0, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h6000, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h2AAA, 1'b0, NO_RESULT},
    '{ROW_ACCESS, '0, '0, 15'h5555, 1'b0, NO_RESULT}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [ADDR_W-1:0]      in_virtual_address = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PAGE_W-1:0]      out_page_number;
  logic                   out_hit;
  logic                   out_evict_valid;
  logic [PAGE_W-1:0]      out_evicted_page;
  logic [FAULT_W-1:0]     out_fault_count;
  logic                   out_stamp_exhausted;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Shadow copy of the replacement table and its settings
  bit                     resident_map [NUM_PAGES];
  logic [STAMP_W-1:0]     page_stamp [NUM_PAGES];
  logic [STAMP_W-1:0]     stamp_clock;
  logic [FAULT_W-1:0]     fault_total;
  logic [LIMIT_W-1:0]     frame_limit_cfg;
  logic [PSIZE_W-1:0]     page_shift_cfg;
  logic                   policy_cfg;

  page_result_t           pending_results [$];
  page_result_t           oldest;

  int unsigned            send_idle_pct = 14;
  int unsigned            recv_stall_pct = 77;
  int unsigned            error_count = 0;
  int unsigned            accesses_checked = 0;
  int unsigned            hits_seen = 0;
  int unsigned            evictions_seen = 0;
  int unsigned            writes_done = 0;
  longint                 cycle_count = 0;

  lru_fifo_page_replacer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_virtual_address  (in_virtual_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_page_number     (out_page_number),
    .out_hit             (out_hit),
    .out_evict_valid     (out_evict_valid),
    .out_evicted_page    (out_evicted_page),
    .out_fault_count     (out_fault_count),
    .out_stamp_exhausted (out_stamp_exhausted),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stamp one page and advance the stamp clock until it saturates
  function automatic void restamp(input int unsigned idx);
    page_stamp[idx] = stamp_clock;
    if (stamp_clock != STAMP_TOP) stamp_clock = stamp_clock + 1'b1;
  endfunction

  // Look up one address, update the shadow table, return the outcome
  function automatic page_result_t replace_page(input logic [ADDR_W-1:0] addr);
    page_result_t r;
    int unsigned shift;
    int unsigned limit;
    int unsigned occupied;
    int unsigned pg;
    int unsigned victim;
    int unsigned k;
    bit found;
    logic [STAMP_W-1:0] best;
    r = '0;
    shift = (page_shift_cfg < MIN_PAGE_SHIFT) ? MIN_PAGE_SHIFT : page_shift_cfg;
    pg = (32'(addr) >> shift) % NUM_PAGES;
    limit = (frame_limit_cfg == 0) ? 1 : frame_limit_cfg;
    occupied = 0;
    for (k = 0; k < NUM_PAGES; k++) occupied += resident_map[k];
    r.page_number = PAGE_W'(pg);
    r.hit = resident_map[pg];
    if (r.hit) begin
      if (policy_cfg == POLICY_LRU) restamp(pg);
    end else begin
      // Table full: drop the oldest resident page, lowest index on a tie
      if (occupied >= limit) begin
        found = 1'b0;
        best = '0;
        victim = 0;
        for (k = 0; k < NUM_PAGES; k++) begin
          if (resident_map[k] && (!found || page_stamp[k] < best)) begin
            found = 1'b1;
            best = page_stamp[k];
            victim = k;
          end
        end
        if (found) begin
          resident_map[victim] = 1'b0;
          r.evict_valid = 1'b1;
          r.evicted_page = PAGE_W'(victim);
        end
      end
      if (fault_total != FAULT_TOP) fault_total = fault_total + 1'b1;
      resident_map[pg] = 1'b1;
      restamp(pg);
    end
    r.fault_count = fault_total;
    r.stamp_exhausted = (stamp_clock == STAMP_TOP);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (error_count < MAX_PRINTED)
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
    error_count++;
  endtask

  // Hold the input side until every outstanding transaction has returned
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Write one register once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_FRAME_LIMIT:    frame_limit_cfg = data[LIMIT_W-1:0];
      CFG_PAGE_SIZE_LOG2: page_shift_cfg = data[PSIZE_W-1:0];
      CFG_POLICY_MODE:    policy_cfg = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    writes_done++;
  endtask

  // Offer one address after a random gap, record its outcome on acceptance
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic typed,
                             input page_result_t want);
    page_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_virtual_address <= ADDR_W'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_virtual_address <= addr;
    do @(posedge clk); while (in_stall);
    predicted = replace_page(addr);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // One random configuration of the three registers, then a reference stream mostly inside a working set
  task automatic run_segment(input int unsigned count);
    int unsigned limit_pick;
    int unsigned shift;
    int unsigned span;
    int unsigned ws;
    int unsigned base;
    int unsigned pg;
    int unsigned n;
    logic [ADDR_W-1:0] addr;
    case ($urandom_range(5))
      0: limit_pick = 1;
      1: limit_pick = 32;
      2: limit_pick = 0;
      3: limit_pick = 63;
      default: limit_pick = $urandom_range(12, 2);
    endcase
    write_reg(CFG_FRAME_LIMIT, CFG_DATA_W'(limit_pick));
    write_reg(CFG_PAGE_SIZE_LOG2, CFG_DATA_W'($urandom_range(63)));
    write_reg(CFG_POLICY_MODE, CFG_DATA_W'($urandom_range(63)));
    shift = (page_shift_cfg < MIN_PAGE_SHIFT) ? MIN_PAGE_SHIFT : page_shift_cfg;
    span = (shift >= ADDR_W) ? 1 : (1 << (ADDR_W - shift));
    ws = ((limit_pick == 0) ? 1 : limit_pick) + $urandom_range(3);
    if (ws > span) ws = span;
    base = $urandom_range(span - 1);
    for (n = 0; n < count; n++) begin
      if (n == count / 2 || $urandom_range(59) == 0) wait_all_results();
      if ($urandom_range(99) < 75) begin
        pg = (base + $urandom_range(ws - 1)) % span;
        addr = ADDR_W'((pg << shift) | ($urandom & ((1 << shift) - 1)));
      end else begin
        addr = ADDR_W'($urandom);
      end
      send_access(addr, 1'b0, NO_RESULT);
    end
  endtask

  // Receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each returned transaction with the oldest outstanding one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        oldest = pending_results.pop_front();
        if (out_page_number !== oldest.page_number)
          report_mismatch("page_number", out_page_number, oldest.page_number);
        if (out_hit !== oldest.hit)
          report_mismatch("hit", out_hit, oldest.hit);
        if (out_evict_valid !== oldest.evict_valid)
          report_mismatch("evict_valid", out_evict_valid, oldest.evict_valid);
        if (out_evicted_page !== oldest.evicted_page)
          report_mismatch("evicted_page", out_evicted_page, oldest.evicted_page);
        if (out_fault_count !== oldest.fault_count)
          report_mismatch("fault_count", out_fault_count, oldest.fault_count);
        if (out_stamp_exhausted !== oldest.stamp_exhausted)
          report_mismatch("stamp_exhausted", out_stamp_exhausted, oldest.stamp_exhausted);
        accesses_checked++;
        hits_seen += out_hit;
        evictions_seen += out_evict_valid;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d transactions outstanding",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned row;
    int unsigned phase;
    int unsigned seg;
    // Shadow state after reset
    foreach (resident_map[k]) begin
      resident_map[k] = 1'b0;
      page_stamp[k] = '0;
    end
    stamp_clock = STAMP_W'(1);
    fault_total = '0;
    frame_limit_cfg = FRAME_LIMIT_RST;
    page_shift_cfg = PAGE_SIZE_RST;
    policy_cfg = POLICY_RST;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    for (row = 0; row < NUM_ROWS; row++) begin
      if (DIRECTED_PLAN[row].kind == ROW_WRITE)
        write_reg(DIRECTED_PLAN[row].reg_idx, DIRECTED_PLAN[row].wdata);
      else
        send_access(DIRECTED_PLAN[row].addr, DIRECTED_PLAN[row].typed,
                    DIRECTED_PLAN[row].want);
    end

    // Random part: sender idles rarely, then receiver does, then neither
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 14; recv_stall_pct = 77; end
        1: begin send_idle_pct = 77; recv_stall_pct = 14; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (seg = 0; seg < SEGMENTS_PER_PHASE; seg++) run_segment(SEGMENT_ITEMS);
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d transactions: %0d hits, %0d evictions, %0d register writes.",
             accesses_checked, hits_seen, evictions_seen, writes_done);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
